// ===== hdl/hbps_pkg.sv =====
package hbps_pkg;

    // Fixed field widths of the request, result and configuration channels.
    localparam int REQ_W  = 2;
    localparam int DATA_W = 8;
    localparam int NIDX_W = 7;
    localparam int OFS_W  = 24;
    localparam int CFG_W  = 8;

    // One skip entry for every byte value.
    localparam int SKIP_DEPTH = 256;

    // Defaults for the top level parameters.
    localparam int MAX_PATTERN_DEF = 128;
    localparam int OFFSET_BITS_DEF = 24;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_HAY   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_START = 2'd2;

endpackage

// ===== hdl/hbps_req_if.sv =====
interface hbps_req_if;
    logic                        valid;
    logic                        ready;
    logic [hbps_pkg::REQ_W-1:0]  req_type;
    logic [hbps_pkg::DATA_W-1:0] data_byte;
    logic [hbps_pkg::NIDX_W-1:0] needle_index;
    logic                        last_byte;

    modport source (output valid, req_type, data_byte, needle_index, last_byte, input ready);
    modport sink   (input valid, req_type, data_byte, needle_index, last_byte, output ready);
endinterface

// ===== hdl/hbps_res_if.sv =====
interface hbps_res_if;
    logic                       valid;
    logic                       ready;
    logic                       found;
    logic [hbps_pkg::OFS_W-1:0] match_offset;

    modport source (output valid, found, match_offset, input ready);
    modport sink   (input valid, found, match_offset, output ready);
endinterface

// ===== hdl/hbps_cfg_if.sv =====
interface hbps_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [hbps_pkg::CFG_W-1:0] needle_length;

    modport source (output valid, needle_length, input ready);
    modport sink   (input valid, needle_length, output ready);
endinterface

// ===== hdl/hbps_ram.sv =====
// Simple dual-port memory: one write port, one read port with registered data.
module hbps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/horspool_byte_pattern_search.sv =====
// A start request keeps the block busy while it fills all 256 skip entries with the length,
// writes one skip entry per pattern byte but the last, then drains the last write and closes.
// At the alignment end, a haystack byte starts a backward compare that keeps the block busy,
// one byte pair at a time (one read port per memory); a result appears the cycle after the
// compare ends. Reset is synchronous, active low.
module horspool_byte_pattern_search #(
    parameter int MAX_PATTERN = hbps_pkg::MAX_PATTERN_DEF,
    parameter int OFFSET_BITS = hbps_pkg::OFFSET_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    hbps_req_if.sink       i_req,
    hbps_res_if.source     o_res,
    hbps_cfg_if.sink       i_cfg
);

    // Index into the pattern store and the window ring.
    localparam int PIDX_W = $clog2(MAX_PATTERN);
    // Wide enough for a pattern length and for a skip value, both up to MAX_PATTERN.
    localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
    localparam int SKIP_AW = $clog2(hbps_pkg::SKIP_DEPTH);

    localparam logic [PIDX_W-1:0] LAST_IDX = PIDX_W'(MAX_PATTERN - 1);
    // Ring slot of the highest stream position; a backward walk that crosses position zero
    // lands here, exactly as the position wraps.
    localparam logic [PIDX_W-1:0] TOP_IDX  =
        PIDX_W'(((64'd1 << OFFSET_BITS) - 64'd1) % MAX_PATTERN);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE = 2'd0;  // takes requests
    localparam logic [1:0] ST_CLR  = 2'd1;  // fills every skip entry with the length
    localparam logic [1:0] ST_BLD  = 2'd2;  // writes skip entries from the pattern bytes
    localparam logic [1:0] ST_CMP  = 2'd3;  // backward compare at the alignment end

    // Control state.
    logic [1:0]                  r_state,         n_state;
    logic [hbps_pkg::CFG_W-1:0]  r_needle_length, n_needle_length;
    logic [LEN_W-1:0]            r_len,           n_len;
    logic                        r_active,        n_active;
    logic [OFFSET_BITS-1:0]      r_pos,           n_pos;
    logic [OFFSET_BITS-1:0]      r_ae,            n_ae;
    logic [PIDX_W-1:0]           r_widx,          n_widx;
    logic [SKIP_AW-1:0]          r_cnt,           n_cnt;
    logic [LEN_W-1:0]            r_iss,           n_iss;
    logic                        r_rdv,           n_rdv;
    logic                        r_out_valid,     n_out_valid;

    // Working payload.
    logic [PIDX_W-1:0]           r_pidx,   n_pidx;
    logic [PIDX_W-1:0]           r_ridx,   n_ridx;
    logic [OFFSET_BITS-1:0]      r_rpos,   n_rpos;
    logic [LEN_W-1:0]            r_bval,   n_bval;
    logic                        r_last,   n_last;
    logic                        r_found,  n_found;
    logic [hbps_pkg::OFS_W-1:0]  r_offset, n_offset;

    // Memory ports.
    logic                        pat_we, pat_re;
    logic [PIDX_W-1:0]           pat_waddr, pat_raddr;
    logic [hbps_pkg::DATA_W-1:0] pat_wdata, pat_q;
    logic                        win_we, win_re;
    logic [PIDX_W-1:0]           win_waddr, win_raddr;
    logic [hbps_pkg::DATA_W-1:0] win_wdata, win_q;
    logic                        skip_we, skip_re;
    logic [SKIP_AW-1:0]          skip_waddr, skip_raddr;
    logic [LEN_W-1:0]            skip_wdata, skip_q;

    logic                        in_ready;
    logic                        in_acc;
    logic [LEN_W-1:0]            len_lim;

    // A new request is taken only when the sequencer is idle and the output register is free
    // or being emptied in this cycle, so a result always finds room when it is produced.
    assign in_ready = (r_state == ST_IDLE) && (!r_out_valid || o_res.ready);
    assign in_acc   = i_req.valid && in_ready;

    assign i_req.ready        = in_ready;
    assign i_cfg.ready        = 1'b1;
    assign o_res.valid        = r_out_valid;
    assign o_res.found        = r_found;
    assign o_res.match_offset = r_offset;

    // The configured length is clamped to the pattern store size when a search starts.
    assign len_lim = (32'(r_needle_length) > MAX_PATTERN) ? LEN_W'(MAX_PATTERN)
                                                          : LEN_W'(r_needle_length);

    always_comb begin
        n_state         = r_state;
        n_needle_length = r_needle_length;
        n_len           = r_len;
        n_active        = r_active;
        n_pos           = r_pos;
        n_ae            = r_ae;
        n_widx          = r_widx;
        n_cnt           = r_cnt;
        n_iss           = r_iss;
        n_rdv           = r_rdv;
        n_out_valid     = r_out_valid && !o_res.ready;
        n_pidx          = r_pidx;
        n_ridx          = r_ridx;
        n_rpos          = r_rpos;
        n_bval          = r_bval;
        n_last          = r_last;
        n_found         = r_found;
        n_offset        = r_offset;

        pat_we     = 1'b0;
        pat_waddr  = PIDX_W'(i_req.needle_index);
        pat_wdata  = i_req.data_byte;
        pat_re     = 1'b0;
        pat_raddr  = r_pidx;
        win_we     = 1'b0;
        win_waddr  = r_widx;
        win_wdata  = i_req.data_byte;
        win_re     = 1'b0;
        win_raddr  = r_ridx;
        skip_we    = 1'b0;
        skip_waddr = r_cnt;
        skip_wdata = r_len;
        skip_re    = 1'b0;
        skip_raddr = i_req.data_byte;

        if (i_cfg.valid) begin
            n_needle_length = i_cfg.needle_length;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (i_req.req_type)
                        hbps_pkg::REQ_LOAD: begin
                            // Loads beyond the pattern store are dropped.
                            pat_we = (32'(i_req.needle_index) < MAX_PATTERN);
                        end
                        hbps_pkg::REQ_START: begin
                            n_len    = len_lim;
                            n_pos    = '0;
                            n_widx   = '0;
                            n_ae     = (len_lim != '0) ? OFFSET_BITS'(len_lim - 1'b1) : '0;
                            n_active = 1'b1;
                            n_cnt    = '0;
                            n_pidx   = '0;
                            n_iss    = (len_lim != '0) ? (len_lim - 1'b1) : '0;
                            n_rdv    = 1'b0;
                            n_state  = ST_CLR;
                        end
                        hbps_pkg::REQ_HAY: begin
                            if (r_active) begin
                                win_we  = 1'b1;
                                // The skip entry of this byte is fetched now; it is the
                                // advance if the compare below fails.
                                skip_re = 1'b1;
                                n_pos   = r_pos + 1'b1;
                                if (r_pos == '1) begin
                                    n_widx = '0;
                                end else if (r_widx == LAST_IDX) begin
                                    n_widx = '0;
                                end else begin
                                    n_widx = r_widx + 1'b1;
                                end
                                if ((r_len != '0) && (r_pos == r_ae)) begin
                                    // This byte closes the alignment: walk back from it.
                                    n_ridx  = r_widx;
                                    n_rpos  = r_pos;
                                    n_pidx  = PIDX_W'(r_len - 1'b1);
                                    n_iss   = r_len;
                                    n_rdv   = 1'b0;
                                    n_last  = i_req.last_byte;
                                    n_state = ST_CMP;
                                end else if (i_req.last_byte) begin
                                    n_active    = 1'b0;
                                    n_out_valid = 1'b1;
                                    n_found     = 1'b0;
                                    n_offset    = '0;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_CLR: begin
                skip_we = 1'b1;
                n_cnt   = r_cnt + 1'b1;
                if (r_cnt == '1) begin
                    n_state = ST_BLD;
                end
            end

            ST_BLD: begin
                // Pattern reads are issued one per cycle; the skip write for a byte
                // follows in the next cycle, addressed by the byte value read.
                if (r_iss != '0) begin
                    pat_re = 1'b1;
                    n_bval = r_len - 1'b1 - LEN_W'(r_pidx);
                    n_pidx = r_pidx + 1'b1;
                    n_iss  = r_iss - 1'b1;
                    n_rdv  = 1'b1;
                end else begin
                    n_rdv  = 1'b0;
                end
                if (r_rdv) begin
                    skip_we    = 1'b1;
                    skip_waddr = pat_q;
                    skip_wdata = r_bval;
                end
                if ((r_iss == '0) && !r_rdv) begin
                    n_state = ST_IDLE;
                end
            end

            ST_CMP: begin
                if (r_iss != '0) begin
                    pat_re = 1'b1;
                    win_re = 1'b1;
                    n_pidx = r_pidx - 1'b1;
                    n_rpos = r_rpos - 1'b1;
                    n_iss  = r_iss - 1'b1;
                    n_rdv  = 1'b1;
                    if (r_rpos == '0) begin
                        n_ridx = TOP_IDX;
                    end else if (r_ridx == '0) begin
                        n_ridx = LAST_IDX;
                    end else begin
                        n_ridx = r_ridx - 1'b1;
                    end
                end else begin
                    n_rdv = 1'b0;
                end
                if (r_rdv) begin
                    if (win_q != pat_q) begin
                        // Mismatch: drop any read in flight and advance the alignment.
                        n_iss   = '0;
                        n_rdv   = 1'b0;
                        n_ae    = r_ae + OFFSET_BITS'(skip_q);
                        n_state = ST_IDLE;
                        if (r_last) begin
                            n_active    = 1'b0;
                            n_out_valid = 1'b1;
                            n_found     = 1'b0;
                            n_offset    = '0;
                        end
                    end else if (r_iss == '0) begin
                        // The last byte pair checked equal: full match.
                        n_active    = 1'b0;
                        n_out_valid = 1'b1;
                        n_found     = 1'b1;
                        n_offset    = hbps_pkg::OFS_W'(r_ae - OFFSET_BITS'(r_len - 1'b1));
                        n_state     = ST_IDLE;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_needle_length <= '0;
            r_len           <= '0;
            r_active        <= 1'b0;
            r_pos           <= '0;
            r_ae            <= '0;
            r_widx          <= '0;
            r_cnt           <= '0;
            r_iss           <= '0;
            r_rdv           <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_needle_length <= n_needle_length;
            r_len           <= n_len;
            r_active        <= n_active;
            r_pos           <= n_pos;
            r_ae            <= n_ae;
            r_widx          <= n_widx;
            r_cnt           <= n_cnt;
            r_iss           <= n_iss;
            r_rdv           <= n_rdv;
            r_out_valid     <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx   <= n_pidx;
        r_ridx   <= n_ridx;
        r_rpos   <= n_rpos;
        r_bval   <= n_bval;
        r_last   <= n_last;
        r_found  <= n_found;
        r_offset <= n_offset;
    end

    // Pattern bytes, written by load requests, read by the build and the compare.
    hbps_ram #(
        .WIDTH (hbps_pkg::DATA_W),
        .DEPTH (MAX_PATTERN)
    ) u_pat_ram (
        .i_clk   (i_clk),
        .i_we    (pat_we),
        .i_waddr (pat_waddr),
        .i_wdata (pat_wdata),
        .i_re    (pat_re),
        .i_raddr (pat_raddr),
        .o_rdata (pat_q)
    );

    // Ring of the most recent haystack bytes.
    hbps_ram #(
        .WIDTH (hbps_pkg::DATA_W),
        .DEPTH (MAX_PATTERN)
    ) u_win_ram (
        .i_clk   (i_clk),
        .i_we    (win_we),
        .i_waddr (win_waddr),
        .i_wdata (win_wdata),
        .i_re    (win_re),
        .i_raddr (win_raddr),
        .o_rdata (win_q)
    );

    // Bad-character skip table, indexed by byte value.
    hbps_ram #(
        .WIDTH (LEN_W),
        .DEPTH (hbps_pkg::SKIP_DEPTH)
    ) u_skip_ram (
        .i_clk   (i_clk),
        .i_we    (skip_we),
        .i_waddr (skip_waddr),
        .i_wdata (skip_wdata),
        .i_re    (skip_re),
        .i_raddr (skip_raddr),
        .o_rdata (skip_q)
    );

endmodule

// ===== hdl/hbps_checker.sv =====
module hbps_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic [hbps_pkg::REQ_W-1:0]  i_req_type,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic                        i_found,
    input logic [hbps_pkg::OFS_W-1:0]  i_offset
);

    // A waiting result keeps its value until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_found) && $stable(i_offset))
        else $error("result changed while stalled");

    // A not-found result carries offset zero.
    a_nf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_found |-> i_offset == '0)
        else $error("not-found result with nonzero offset");

    // Loads and starts never raise a result.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready &&
        (i_req_type == hbps_pkg::REQ_LOAD || i_req_type == hbps_pkg::REQ_START)
        |=> !$rose(i_out_valid))
        else $error("result raised by a load or start request");

    // A start begins the skip table build, so the next request must wait.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_req_type == hbps_pkg::REQ_START |=> !i_in_ready)
        else $error("request taken during skip table build");

endmodule

bind horspool_byte_pattern_search hbps_checker u_hbps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_req_type  (i_req.req_type),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_found     (o_res.found),
    .i_offset    (o_res.match_offset)
);

// ===== dv/tb_horspool_byte_pattern_search.sv =====
module tb_horspool_byte_pattern_search;
    timeunit 1ns;
    timeprecision 1ps;

    // Geometry of the block under test, taken from its default parameters.
    localparam int PAT_MAX = hbps_pkg::MAX_PATTERN_DEF;
    localparam int POS_W   = hbps_pkg::OFFSET_BITS_DEF;

    // The one request code that the package leaves unnamed; the block must ignore it.
    localparam logic [hbps_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

    // A start keeps the block busy while it builds the skip table, and a compare at an
    // alignment end while it walks back, so this many quiet cycles leave it idle for sure.
    localparam int SETTLE_CYCLES   = 450;
    localparam int RANDOM_REQUESTS = 1200;
    localparam int IDLE_PERCENT    = 7;

    typedef struct packed {
        logic [hbps_pkg::REQ_W-1:0]  kind;
        logic [hbps_pkg::DATA_W-1:0] data;
        logic [hbps_pkg::NIDX_W-1:0] idx;
        logic                        tail;
    } t_search_req;

    typedef struct packed {
        logic                       found;
        logic [hbps_pkg::OFS_W-1:0] offset;
    } t_search_res;

    logic i_clk;
    logic i_rst_n;

    hbps_req_if req_bus ();
    hbps_res_if res_bus ();
    hbps_cfg_if cfg_bus ();

    horspool_byte_pattern_search dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_res   (res_bus),
        .i_cfg   (cfg_bus)
    );

    // Shadow copy of everything the search keeps. The register shadow follows each
    // accepted configuration write; the rest follows each accepted request.
    logic [hbps_pkg::CFG_W-1:0]  len_reg;
    logic [hbps_pkg::DATA_W-1:0] pat_shadow [PAT_MAX];
    bit                          pat_loaded [PAT_MAX];
    logic [7:0]                  skip_shadow [hbps_pkg::SKIP_DEPTH];
    logic [hbps_pkg::DATA_W-1:0] ring_shadow [PAT_MAX];
    logic [POS_W-1:0]            stream_pos;
    logic [POS_W-1:0]            align_end;
    bit                          searching;
    int unsigned                 live_len;

    // Search results still owed by the block, oldest first.
    t_search_res pending_results [$];

    // When set, neither side of the request or result channels inserts idle cycles.
    bit calm;

    int errors;
    int counted_requests;
    int searches_started;
    int found_seen;
    int missing_seen;

    always #4 i_clk = ~i_clk;

    // Limit on the whole run, far above the slowest legal run.
    initial begin
        #10ms;
        $display("horspool_byte_pattern_search verification failed");
        $finish;
    end

    // Applies one accepted request to the shadow state and queues any result it causes.
    // Returns 0 when the block is expected to ignore the request.
    function automatic bit predict_search(input t_search_req r);
        int unsigned      len;
        int unsigned      i;
        int unsigned      back;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] spot;
        bit               hit;
        t_search_res      res;

        if (r.kind == hbps_pkg::REQ_LOAD) begin
            // The index field cannot exceed the store, so every load lands.
            pat_shadow[r.idx] = r.data;
            pat_loaded[r.idx] = 1'b1;
            return 1'b1;
        end
        if (r.kind == hbps_pkg::REQ_START) begin
            // Latch the clamped length, then build the bad-character table: every byte
            // value skips a whole pattern, each pattern byte but the last skips less.
            len = (len_reg > PAT_MAX) ? PAT_MAX : len_reg;
            live_len = len;
            for (i = 0; i < hbps_pkg::SKIP_DEPTH; i++)
                skip_shadow[i] = 8'(len);
            for (i = 0; i + 1 < len; i++)
                skip_shadow[pat_shadow[i]] = 8'(len - 1 - i);
            stream_pos = '0;
            align_end = (len > 0) ? POS_W'(len - 1) : '0;
            searching = 1'b1;
            searches_started++;
            return 1'b1;
        end
        if (r.kind != hbps_pkg::REQ_HAY || !searching)
            return 1'b0;

        len = live_len;
        pos = stream_pos;
        ring_shadow[pos % PAT_MAX] = r.data;
        stream_pos = pos + 1'b1;

        if (len > 0 && pos == align_end) begin
            // Compare backwards from the alignment end; the first mismatch stops it.
            hit = 1'b1;
            for (back = 0; back < len; back++) begin
                spot = align_end - POS_W'(back);
                if (ring_shadow[spot % PAT_MAX] != pat_shadow[len - 1 - back]) begin
                    hit = 1'b0;
                    break;
                end
            end
            if (hit) begin
                searching = 1'b0;
                res.found = 1'b1;
                res.offset = hbps_pkg::OFS_W'(align_end - POS_W'(len - 1));
                pending_results.push_back(res);
                return 1'b1;
            end
            align_end = align_end + POS_W'(skip_shadow[ring_shadow[align_end % PAT_MAX]]);
        end

        if (r.tail) begin
            // The region ran out without a match.
            searching = 1'b0;
            res.found = 1'b0;
            res.offset = '0;
            pending_results.push_back(res);
        end
        return 1'b1;
    endfunction

    function automatic t_search_req pack_req(input logic [hbps_pkg::REQ_W-1:0] kind,
                                             input logic [hbps_pkg::DATA_W-1:0] data,
                                             input logic [hbps_pkg::NIDX_W-1:0] idx,
                                             input logic tail);
        t_search_req r;
        r.kind = kind;
        r.data = data;
        r.idx  = idx;
        r.tail = tail;
        return r;
    endfunction

    // Sends one request and waits for its handshake. Valid is left high on purpose so
    // that back-to-back requests need no bubble; whoever stops sending lowers it.
    task automatic send_req(input t_search_req r);
        while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
            req_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_bus.valid        <= 1'b1;
        req_bus.req_type     <= r.kind;
        req_bus.data_byte    <= r.data;
        req_bus.needle_index <= r.idx;
        req_bus.last_byte    <= r.tail;
        do @(posedge i_clk); while (req_bus.ready !== 1'b1);
        if (predict_search(r))
            counted_requests++;
    endtask

    // Stops sending, waits for every owed result, then lets any result-free work
    // (a skip table build or a compare) finish so that the block is truly idle.
    task automatic wait_drained();
        req_bus.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes the pattern length register. Callers make sure the block is idle first.
    task automatic write_length(input logic [hbps_pkg::CFG_W-1:0] value);
        cfg_bus.valid         <= 1'b1;
        cfg_bus.needle_length <= value;
        do @(posedge i_clk); while (cfg_bus.ready !== 1'b1);
        cfg_bus.valid <= 1'b0;
        len_reg = value;
    endtask

    // Result side: check every accepted result against the oldest expectation, and
    // stall the channel at random.
    always @(posedge i_clk) begin : result_check
        t_search_res want;
        if (i_rst_n) begin
            if (res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result: found=%0d match_offset=%0h",
                           res_bus.found, res_bus.match_offset);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (res_bus.found !== want.found) begin
                        $error("found: expected %0d, actual %0d", want.found, res_bus.found);
                        errors++;
                    end
                    if (res_bus.match_offset !== want.offset) begin
                        $error("match_offset: expected %0h, actual %0h",
                               want.offset, res_bus.match_offset);
                        errors++;
                    end
                    if (want.found)
                        found_seen++;
                    else
                        missing_seen++;
                end
            end
            res_bus.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Haystack bytes and the unused code while no search runs must both vanish,
    // even when the byte claims to end a region.
    task automatic test_idle_requests();
        send_req(pack_req(hbps_pkg::REQ_HAY, 8'hFF, 7'h7F, 1'b1));
        send_req(pack_req(REQ_UNUSED, 8'hA5, 7'h55, 1'b1));
    endtask

    // With length zero nothing can match, so the final byte reports not-found.
    task automatic test_zero_length();
        wait_drained();
        write_length(8'd0);
        send_req(pack_req(hbps_pkg::REQ_START, 8'h00, 7'h00, 1'b0));
        send_req(pack_req(hbps_pkg::REQ_HAY, 8'h00, 7'h00, 1'b0));
        send_req(pack_req(hbps_pkg::REQ_HAY, 8'h5A, 7'h2A, 1'b1));
    endtask

    // A three-byte pattern that spans both byte extremes. The first alignment misses
    // and skips by one, and the match completes on the byte marked final, so only the
    // match is reported. The load at the top index is never compared.
    task automatic test_match_on_final_byte();
        wait_drained();
        write_length(8'd3);
        send_req(pack_req(hbps_pkg::REQ_LOAD, 8'h00, 7'd0, 1'b0));
        send_req(pack_req(hbps_pkg::REQ_LOAD, 8'hFF, 7'd1, 1'b1));
        send_req(pack_req(hbps_pkg::REQ_LOAD, 8'h80, 7'd2, 1'b0));
        send_req(pack_req(hbps_pkg::REQ_LOAD, 8'hFF, 7'h7F, 1'b0));
        send_req(pack_req(hbps_pkg::REQ_START, 8'hFF, 7'h7F, 1'b1));
        send_req(pack_req(hbps_pkg::REQ_HAY, 8'h11, 7'h00, 1'b0));
        send_req(pack_req(hbps_pkg::REQ_HAY, 8'h00, 7'h00, 1'b0));
        send_req(pack_req(hbps_pkg::REQ_HAY, 8'hFF, 7'h00, 1'b0));
        send_req(pack_req(hbps_pkg::REQ_HAY, 8'h80, 7'h00, 1'b1));
    endtask

    // Same pattern, a region that never contains it.
    task automatic test_no_match();
        send_req(pack_req(hbps_pkg::REQ_START, 8'h00, 7'h00, 1'b0));
        send_req(pack_req(hbps_pkg::REQ_HAY, 8'h80, 7'h00, 1'b0));
        send_req(pack_req(hbps_pkg::REQ_HAY, 8'h80, 7'h00, 1'b0));
        send_req(pack_req(hbps_pkg::REQ_HAY, 8'h80, 7'h00, 1'b0));
        send_req(pack_req(hbps_pkg::REQ_HAY, 8'h00, 7'h00, 1'b1));
    endtask

    // A pattern byte replaced mid-search is compared at once, while the skip table
    // keeps what the start built.
    task automatic test_live_pattern_update();
        send_req(pack_req(hbps_pkg::REQ_START, 8'h00, 7'h00, 1'b0));
        send_req(pack_req(hbps_pkg::REQ_HAY, 8'h00, 7'h00, 1'b0));
        send_req(pack_req(hbps_pkg::REQ_HAY, 8'hFF, 7'h00, 1'b0));
        send_req(pack_req(hbps_pkg::REQ_LOAD, 8'h7F, 7'd2, 1'b0));
        send_req(pack_req(hbps_pkg::REQ_HAY, 8'h7F, 7'h00, 1'b1));
    endtask

    // One random search: maybe a new length, a fresh pattern, a start, then a region
    // that often holds a planted copy of the pattern. Some regions are cut short, some
    // lengths are written after the start, and noise requests are mixed in.
    task automatic run_random_search(input int round);
        logic [hbps_pkg::CFG_W-1:0]  cfg_val;
        logic [hbps_pkg::DATA_W-1:0] hay [$];
        int unsigned                 eff;
        int unsigned                 hay_len;
        int unsigned                 plant_at;
        int unsigned                 n;
        int unsigned                 pick;
        bit                          change;
        bit                          write_after;
        bit                          reload;
        bit                          narrow;
        bit                          broken;

        // The first rounds force the extreme lengths, including one above the store.
        case (round)
            0: cfg_val = 8'd1;
            1: cfg_val = 8'd128;
            2: cfg_val = 8'd255;
            3: cfg_val = 8'd2;
            default: begin
                pick = $urandom_range(99);
                if (pick < 8)
                    cfg_val = 8'd0;
                else if (pick < 13)
                    cfg_val = 8'($urandom_range(128, 255));
                else if (pick < 38)
                    cfg_val = 8'($urandom_range(9, 32));
                else
                    cfg_val = 8'($urandom_range(1, 8));
            end
        endcase
        change = (round < 4) || ($urandom_range(3) != 0);
        write_after = change && (round >= 4) && ($urandom_range(3) == 0);
        narrow = ($urandom_range(2) == 0);
        reload = ($urandom_range(3) != 0);
        broken = ($urandom_range(9) == 0);

        if (change && !write_after) begin
            wait_drained();
            write_length(cfg_val);
        end

        // Every entry the coming start will use must hold a loaded byte.
        eff = (len_reg > PAT_MAX) ? PAT_MAX : len_reg;
        for (n = 0; n < eff; n++)
            if (reload || !pat_loaded[n])
                send_req(pack_req(hbps_pkg::REQ_LOAD,
                                  narrow ? 8'($urandom_range(2)) * 8'h55 : 8'($urandom),
                                  hbps_pkg::NIDX_W'(n), 1'($urandom)));
        send_req(pack_req(hbps_pkg::REQ_START, 8'($urandom), hbps_pkg::NIDX_W'($urandom),
                          1'($urandom)));

        // A length written while a search runs only counts from the next start.
        if (write_after) begin
            wait_drained();
            write_length(cfg_val);
        end

        eff = live_len;
        hay_len = eff + $urandom_range(1, 24);
        hay.delete();
        for (n = 0; n < hay_len; n++)
            hay.push_back(narrow ? 8'($urandom_range(2)) * 8'h55 : 8'($urandom));
        if (eff > 0 && $urandom_range(9) < 6) begin
            plant_at = $urandom_range(hay_len - eff);
            for (n = 0; n < eff; n++)
                hay[plant_at + n] = pat_shadow[n];
        end

        for (n = 0; n < hay_len; n++) begin
            if ($urandom_range(29) == 0) begin
                if ($urandom_range(1) == 0)
                    send_req(pack_req(REQ_UNUSED, 8'($urandom),
                                      hbps_pkg::NIDX_W'($urandom), 1'($urandom)));
                else
                    send_req(pack_req(hbps_pkg::REQ_LOAD, 8'($urandom),
                                      hbps_pkg::NIDX_W'($urandom), 1'($urandom)));
            end
            send_req(pack_req(hbps_pkg::REQ_HAY, hay[n], hbps_pkg::NIDX_W'($urandom),
                              !broken && (n == hay_len - 1)));
        end
    endtask

    task automatic test_random_searches();
        int base;
        int round;
        base = counted_requests;
        round = 0;
        while (counted_requests - base < RANDOM_REQUESTS) begin
            // A stretch of rounds in the middle runs with no idling on either side.
            calm = (round >= 5 && round < 13);
            run_random_search(round);
            round++;
        end
        calm = 1'b0;
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        req_bus.valid = 1'b0;
        req_bus.req_type = hbps_pkg::REQ_LOAD;
        req_bus.data_byte = '0;
        req_bus.needle_index = '0;
        req_bus.last_byte = 1'b0;
        res_bus.ready = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.needle_length = '0;

        // The shadow starts where the block does after reset: register zero, no search.
        len_reg = '0;
        foreach (pat_loaded[k])
            pat_loaded[k] = 1'b0;
        stream_pos = '0;
        align_end = '0;
        searching = 1'b0;
        live_len = 0;
        calm = 1'b0;
        errors = 0;
        counted_requests = 0;
        searches_started = 0;
        found_seen = 0;
        missing_seen = 0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_requests();
        test_zero_length();
        test_match_on_final_byte();
        test_no_match();
        test_live_pattern_update();
        test_random_searches();
        wait_drained();

        $display("Run covered %0d live requests across %0d searches, lengths 0 to 255.",
                 counted_requests, searches_started);
        $display("Checked %0d match results and %0d not-found results, %0d mismatches.",
                 found_seen, missing_seen, errors);
        if (errors == 0)
            $display("horspool_byte_pattern_search verification clean");
        else
            $display("horspool_byte_pattern_search verification failed");
        $finish;
    end

endmodule
